FILE: hdl/lennard_jones_particle_update_unit_assert.svh
// Assertion macros shared by the particle update unit.
// Define ASSERT_OFF to compile the checks out.
`ifndef LENNARD_JONES_PARTICLE_UPDATE_UNIT_ASSERT_SVH
`define LENNARD_JONES_PARTICLE_UPDATE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Clocked check, idle while reset is held low.
`define LJ_ASSERT_RST(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("particle update unit check failed");
// Clocked check that also holds during reset.
`define LJ_ASSERT_CLK(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("particle update unit check failed");
`else
`define LJ_ASSERT_RST(lbl, clk, rstn, prop)
`define LJ_ASSERT_CLK(lbl, clk, prop)
`endif

`endif

FILE: hdl/lj_pkg.sv
`timescale 1ns / 1ps

package lj_pkg;

  // Geometry and number format
  localparam int AXES        = 3;
  localparam int FIELD_AXES  = 3;
  localparam int FRAC_BITS   = 16;
  localparam int DATA_W      = 32;
  localparam int DT_W        = 16;
  localparam int BOX_W       = 31;
  localparam int MASS_W      = 16;
  localparam int CFG_IDX_W   = 3;

  // Intermediate magnitudes saturate at 2^VAL_W-1, velocity deltas at 2^DCAP_W-1
  localparam int VAL_W   = 64 - FRAC_BITS;
  localparam int DCAP_W  = 64 - DT_W;
  localparam int RES_W   = (VAL_W > DCAP_W) ? VAL_W : DCAP_W;
  localparam int MAG_W   = DATA_W + 1;

  // Digit-serial multiplier: DIG multiplier bits per cycle
  localparam int DIG       = 4;
  localparam int MA_W      = RES_W + 1;
  localparam int MB_W      = ((RES_W + DIG - 1) / DIG) * DIG;
  localparam int PROD_W    = MA_W + MB_W;
  localparam int MUL_STEPS = MB_W / DIG;
  localparam int MCNT_W    = $clog2(MUL_STEPS + 1);

  // Restoring divider for 2^(2F) / r^2, one quotient bit per cycle
  localparam int R2_W   = VAL_W + 2;
  localparam int Q_W    = 2 * FRAC_BITS + 1;
  localparam int DCNT_W = $clog2(Q_W + 1);

  localparam int AX_W = (AXES > 1) ? $clog2(AXES) : 1;

  localparam logic [RES_W-1:0] CAP_VAL  = RES_W'({VAL_W{1'b1}});
  localparam logic [RES_W-1:0] DCAP_VAL = RES_W'({DCAP_W{1'b1}});

  localparam logic [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // sigma^2 and 24*epsilon per mass pairing
  localparam int S2_W = 4;
  localparam int K_W  = 11;
  localparam logic [S2_W-1:0] S2_DIFF  = 4'd4;
  localparam logic [S2_W-1:0] S2_ONE   = 4'd1;
  localparam logic [S2_W-1:0] S2_OTHER = 4'd9;
  localparam logic [K_W-1:0]  K24_DIFF  = 11'd360;
  localparam logic [K_W-1:0]  K24_ONE   = 11'd72;
  localparam logic [K_W-1:0]  K24_OTHER = 11'd1440;
  localparam logic [MASS_W-1:0] MASS_ONE = 16'd1;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_FORCE = 2'd1,
    REQ_MOVE  = 2'd2
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOX_X = 3'd0,
    CFG_BOX_Y = 3'd1,
    CFG_BOX_Z = 3'd2,
    CFG_DT    = 3'd3,
    CFG_MASS  = 3'd4
  } cfg_e;

  // Multiplier micro-operations
  typedef enum logic [3:0] {
    MOP_SQR, MOP_U, MOP_U2, MOP_U3, MOP_U6, MOP_A, MOP_B,
    MOP_FM, MOP_T, MOP_DV, MOP_MV
  } mop_e;

  typedef enum logic [1:0] {
    SH_NONE, SH_FRAC, SH_DT
  } sh_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MGO, ST_MWAIT, ST_DGO, ST_DWAIT, ST_DONE
  } state_e;

  typedef struct packed {
    logic            accept;
    logic            load;
    logic            mul_start;
    mop_e            mop;
    logic [AX_W-1:0] axis;
    logic            div_start;
    logic            out_load;
  } lj_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
  } lj_sts_t;

endpackage

FILE: hdl/lj_mul.sv
`timescale 1ns / 1ps

// Digit-serial multiplier, MSB digit first, saturating shifted result
module lj_mul (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [lj_pkg::MA_W-1:0]  a_i,
  input  logic [lj_pkg::MB_W-1:0]  b_i,
  input  lj_pkg::sh_e              sh_i,
  output logic                     done_o,
  output logic [lj_pkg::RES_W-1:0] res_o
);
  import lj_pkg::*;

  logic [PROD_W-1:0]    acc_q, acc_d;
  logic [MA_W-1:0]      a_q;
  logic [MB_W-1:0]      b_q;
  sh_e                  sh_q;
  logic [MCNT_W-1:0]    cnt_q;
  logic                 busy_q, done_q;
  logic [MA_W+DIG-1:0]  pp;
  logic [PROD_W-1:0]    shifted;
  logic [RES_W-1:0]     cap;

  // one digit partial product per cycle
  assign pp    = a_q * b_q[MB_W-1 -: DIG];
  assign acc_d = (acc_q << DIG) + {{(PROD_W-MA_W-DIG){1'b0}}, pp};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= MCNT_W'(MUL_STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == MCNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      a_q   <= a_i;
      b_q   <= b_i;
      sh_q  <= sh_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
      b_q   <= b_q << DIG;
    end
  end

  // scale and saturate
  always_comb begin
    case (sh_q)
      SH_FRAC: begin shifted = acc_q >> FRAC_BITS; cap = CAP_VAL;  end
      SH_DT:   begin shifted = acc_q >> DT_W;      cap = DCAP_VAL; end
      default: begin shifted = acc_q;              cap = CAP_VAL;  end
    endcase
    res_o = (shifted > PROD_W'(cap)) ? cap : shifted[RES_W-1:0];
  end

  assign done_o = done_q;

endmodule

FILE: hdl/lj_div.sv
`timescale 1ns / 1ps

// Restoring divider: quot = min(2^(2F) / max(den,1), CAP)
module lj_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [lj_pkg::R2_W-1:0]  den_i,
  output logic                     done_o,
  output logic [lj_pkg::VAL_W-1:0] quot_o
);
  import lj_pkg::*;

  logic [R2_W-1:0]      den_q, rem_q;
  logic [Q_W-1:0]       quo_q;
  logic [DCNT_W-1:0]    cnt_q;
  logic                 busy_q, done_q;
  logic                 dbit, ge;
  logic [R2_W:0]        trial, diff;
  logic [Q_W+VAL_W-1:0] quo_ext;

  // dividend is a single one bit at position 2F
  assign dbit  = (cnt_q == DCNT_W'(Q_W));
  assign trial = {rem_q, dbit};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DCNT_W'(Q_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DCNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= (den_i == '0) ? R2_W'(1) : den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[R2_W-1:0] : trial[R2_W-1:0];
      quo_q <= {quo_q[Q_W-2:0], ge};
    end
  end

  assign quo_ext = (Q_W+VAL_W)'(quo_q);
  assign quot_o  = (quo_ext > (Q_W+VAL_W)'(CAP_VAL[VAL_W-1:0])) ? CAP_VAL[VAL_W-1:0]
                                                                 : quo_ext[VAL_W-1:0];
  assign done_o  = done_q;

endmodule

FILE: hdl/lj_dp.sv
`timescale 1ns / 1ps

// Datapath: particle state, config, force intermediates, shared mul and div
module lj_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lj_pkg::lj_cmd_t              cmd_i,
  output lj_pkg::lj_sts_t              sts_o,
  input  logic                         cfg_we_i,
  input  logic [lj_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lj_pkg::BOX_W-1:0]     cfg_wdata_i,
  input  logic [lj_pkg::MASS_W-1:0]    other_mass_i,
  input  logic [lj_pkg::DATA_W-1:0]    coord_i [lj_pkg::FIELD_AXES],
  input  logic [lj_pkg::DATA_W-1:0]    speed_i [lj_pkg::FIELD_AXES],
  output logic [lj_pkg::DATA_W-1:0]    pos_o   [lj_pkg::FIELD_AXES],
  output logic [lj_pkg::DATA_W-1:0]    vel_o   [lj_pkg::FIELD_AXES]
);
  import lj_pkg::*;

  localparam int NV_W = RES_W + 2;
  localparam int P_W  = RES_W + 3;

  logic [DATA_W-1:0] pos_q [AXES];
  logic [DATA_W-1:0] vel_q [AXES];
  logic [BOX_W-1:0]  box_q [FIELD_AXES];
  logic [DT_W-1:0]   dt_q;
  logic [MASS_W-1:0] own_mass_q;

  logic [MAG_W-1:0]  dmag_q [AXES];
  logic              dneg_q [AXES];
  logic [R2_W-1:0]   r2_q;
  logic [VAL_W-1:0]  q_q, u_q, u2_q, u3_q, u6_q, fm_q, t_q;
  logic [VAL_W:0]    a_q, g_q;
  logic              negf_q;
  logic [S2_W-1:0]   s2_q, s2_d;
  logic [K_W-1:0]    k24_q, k24_d;
  logic [DATA_W-1:0] out_pos_q [FIELD_AXES];
  logic [DATA_W-1:0] out_vel_q [FIELD_AXES];

  logic [MAG_W-1:0]  dsum [AXES];
  logic [MA_W-1:0]   mul_a;
  logic [MB_W-1:0]   mul_b;
  sh_e               mul_sh;
  logic              mul_done, div_done;
  logic [RES_W-1:0]  mres;
  logic [VAL_W-1:0]  quot;

  logic [DATA_W-1:0] v_cur, p_cur, vmag, vabs_sat;
  logic [VAL_W:0]    b_ext;
  logic              negf_d;
  logic [VAL_W:0]    g_d;
  logic [NV_W-1:0]   nv;
  logic [NV_W-DATA_W:0] nv_hi;
  logic [DATA_W-1:0] vdv;
  logic signed [P_W-1:0] p0, p1, p2, wx;
  logic [DATA_W-1:0] pmv, vmv, v1;
  logic [DATA_W-1:0] pos_pad [FIELD_AXES];
  logic [DATA_W-1:0] vel_pad [FIELD_AXES];

  // mass pairing picks sigma^2 and 24*epsilon
  always_comb begin
    if (other_mass_i != own_mass_q) begin
      s2_d = S2_DIFF;  k24_d = K24_DIFF;
    end else if (own_mass_q == MASS_ONE) begin
      s2_d = S2_ONE;   k24_d = K24_ONE;
    end else begin
      s2_d = S2_OTHER; k24_d = K24_OTHER;
    end
  end

  // offsets to the other particle, exact in 33 bits
  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      dsum[i] = {coord_i[i][DATA_W-1], coord_i[i]} - {pos_q[i][DATA_W-1], pos_q[i]};
    end
  end

  assign v_cur = vel_q[cmd_i.axis];
  assign p_cur = pos_q[cmd_i.axis];
  assign vmag  = v_cur[DATA_W-1] ? (DATA_W'(0) - v_cur) : v_cur;

  // multiplier operand select
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_sh = SH_NONE;
    case (cmd_i.mop)
      MOP_SQR: begin
        mul_a = MA_W'(dmag_q[cmd_i.axis]); mul_b = MB_W'(dmag_q[cmd_i.axis]);
        mul_sh = SH_FRAC;
      end
      MOP_U:  begin mul_a = MA_W'(s2_q); mul_b = MB_W'(q_q);  end
      MOP_U2: begin mul_a = MA_W'(u_q);  mul_b = MB_W'(u_q);  mul_sh = SH_FRAC; end
      MOP_U3: begin mul_a = MA_W'(u2_q); mul_b = MB_W'(u_q);  mul_sh = SH_FRAC; end
      MOP_U6: begin mul_a = MA_W'(u3_q); mul_b = MB_W'(u3_q); mul_sh = SH_FRAC; end
      MOP_A:  begin mul_a = MA_W'(u6_q); mul_b = MB_W'(q_q);  mul_sh = SH_FRAC; end
      MOP_B:  begin mul_a = MA_W'(u3_q); mul_b = MB_W'(q_q);  mul_sh = SH_FRAC; end
      MOP_FM: begin mul_a = MA_W'(g_q);  mul_b = MB_W'(k24_q); end
      MOP_T: begin
        mul_a = MA_W'(dmag_q[cmd_i.axis]); mul_b = MB_W'(fm_q); mul_sh = SH_FRAC;
      end
      MOP_DV: begin mul_a = MA_W'(t_q);  mul_b = MB_W'(dt_q); mul_sh = SH_DT; end
      MOP_MV: begin mul_a = MA_W'(vmag); mul_b = MB_W'(dt_q); mul_sh = SH_DT; end
      default: ;
    endcase
  end

  lj_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .sh_i    (mul_sh),
    .done_o  (mul_done),
    .res_o   (mres)
  );

  lj_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .den_i   (r2_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign sts_o.mul_done = mul_done;
  assign sts_o.div_done = div_done;

  // force sign and |A - B|
  assign b_ext  = (VAL_W+1)'(mres[VAL_W-1:0]);
  assign negf_d = a_q >= b_ext;
  assign g_d    = negf_d ? (a_q - b_ext) : (b_ext - a_q);

  // velocity kick, saturated to 32 bits
  always_comb begin
    if (dneg_q[cmd_i.axis] != negf_q) begin
      nv = {{(NV_W-DATA_W){v_cur[DATA_W-1]}}, v_cur} - {2'b00, mres};
    end else begin
      nv = {{(NV_W-DATA_W){v_cur[DATA_W-1]}}, v_cur} + {2'b00, mres};
    end
    nv_hi = nv[NV_W-1:DATA_W-1];
    if ((&nv_hi) || !(|nv_hi)) begin
      vdv = nv[DATA_W-1:0];
    end else begin
      vdv = nv[NV_W-1] ? DATA_MIN : DATA_MAX;
    end
  end

  // move step with reflection off zero and the wall, then clamp
  always_comb begin
    vabs_sat = (v_cur == DATA_MIN) ? DATA_MAX : vmag;
    wx = {{(P_W-BOX_W){1'b0}}, box_q[cmd_i.axis]};
    if (v_cur[DATA_W-1]) begin
      p0 = {{(P_W-DATA_W){p_cur[DATA_W-1]}}, p_cur} - {3'b000, mres};
    end else begin
      p0 = {{(P_W-DATA_W){p_cur[DATA_W-1]}}, p_cur} + {3'b000, mres};
    end
    p1 = (p0 < 0) ? -p0 : p0;
    v1 = (p0 < 0) ? vabs_sat : v_cur;
    p2 = (p1 > wx) ? ((wx <<< 1) - p1) : p1;
    vmv = (p1 > wx) ? (DATA_W'(0) - vabs_sat) : v1;
    if (p2 < 0) begin
      pmv = '0;
    end else if (p2 > wx) begin
      pmv = wx[DATA_W-1:0];
    end else begin
      pmv = p2[DATA_W-1:0];
    end
  end

  // particle state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < AXES; i++) begin
        pos_q[i] <= '0;
        vel_q[i] <= '0;
      end
    end else if (cmd_i.load) begin
      for (int i = 0; i < AXES; i++) begin
        pos_q[i] <= coord_i[i];
        vel_q[i] <= speed_i[i];
      end
    end else if (mul_done && cmd_i.mop == MOP_DV) begin
      vel_q[cmd_i.axis] <= vdv;
    end else if (mul_done && cmd_i.mop == MOP_MV) begin
      pos_q[cmd_i.axis] <= pmv;
      vel_q[cmd_i.axis] <= vmv;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FIELD_AXES; i++) begin
        box_q[i] <= BOX_W'(6553600);
      end
      dt_q       <= DT_W'(655);
      own_mass_q <= MASS_ONE;
    end else if (cfg_we_i) begin
      case (cfg_e'(cfg_idx_i))
        CFG_BOX_X: box_q[0]   <= cfg_wdata_i;
        CFG_BOX_Y: box_q[1]   <= cfg_wdata_i;
        CFG_BOX_Z: box_q[2]   <= cfg_wdata_i;
        CFG_DT:    dt_q       <= cfg_wdata_i[DT_W-1:0];
        CFG_MASS:  own_mass_q <= cfg_wdata_i[MASS_W-1:0];
        default: ;
      endcase
    end
  end

  // force intermediates
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      for (int i = 0; i < AXES; i++) begin
        dneg_q[i] <= dsum[i][MAG_W-1];
        dmag_q[i] <= dsum[i][MAG_W-1] ? (MAG_W'(0) - dsum[i]) : dsum[i];
      end
      r2_q  <= '0;
      s2_q  <= s2_d;
      k24_q <= k24_d;
    end
    if (div_done) begin
      q_q <= quot;
    end
    if (mul_done) begin
      case (cmd_i.mop)
        MOP_SQR: r2_q <= r2_q + R2_W'(mres);
        MOP_U:   u_q  <= mres[VAL_W-1:0];
        MOP_U2:  u2_q <= mres[VAL_W-1:0];
        MOP_U3:  u3_q <= mres[VAL_W-1:0];
        MOP_U6:  u6_q <= mres[VAL_W-1:0];
        MOP_A:   a_q  <= {mres[VAL_W-1:0], 1'b0};
        MOP_B: begin
          negf_q <= negf_d;
          g_q    <= g_d;
        end
        MOP_FM:  fm_q <= mres[VAL_W-1:0];
        MOP_T:   t_q  <= mres[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  // result register; axes past AXES read zero
  always_comb begin
    for (int i = 0; i < FIELD_AXES; i++) begin
      pos_pad[i] = '0;
      vel_pad[i] = '0;
    end
    for (int i = 0; i < AXES; i++) begin
      pos_pad[i] = pos_q[i];
      vel_pad[i] = vel_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      for (int i = 0; i < FIELD_AXES; i++) begin
        out_pos_q[i] <= pos_pad[i];
        out_vel_q[i] <= vel_pad[i];
      end
    end
  end

  assign pos_o = out_pos_q;
  assign vel_o = out_vel_q;

endmodule

FILE: hdl/lj_ctrl.sv
`timescale 1ns / 1ps

`include "lennard_jones_particle_update_unit_assert.svh"

// Controller: sequences multiplier and divider micro-operations per item
module lj_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      req_type_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output lj_pkg::lj_cmd_t cmd_o,
  input  lj_pkg::lj_sts_t sts_i
);
  import lj_pkg::*;

  localparam logic [AX_W-1:0] AX_LAST = AX_W'(AXES - 1);

  state_e          state_q, state_d;
  mop_e            mop_q, mop_d;
  logic [AX_W-1:0] ax_q, ax_d;
  logic            out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mop_q       <= MOP_SQR;
      ax_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mop_q       <= mop_d;
      ax_q        <= ax_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    mop_d       = mop_q;
    ax_d        = ax_q;
    out_valid_d = out_valid_q;
    in_ready_o  = 1'b0;
    cmd_o           = '0;
    cmd_o.mop       = mop_q;
    cmd_o.axis      = ax_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          ax_d = '0;
          case (req_e'(req_type_i))
            REQ_LOAD: begin
              cmd_o.load = 1'b1;
              state_d = ST_DONE;
            end
            REQ_FORCE: begin
              mop_d = MOP_SQR;
              state_d = ST_MGO;
            end
            REQ_MOVE: begin
              mop_d = MOP_MV;
              state_d = ST_MGO;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_MGO: begin
        cmd_o.mul_start = 1'b1;
        state_d = ST_MWAIT;
      end
      ST_MWAIT: begin
        if (sts_i.mul_done) begin
          state_d = ST_MGO;
          case (mop_q)
            MOP_SQR: begin
              if (ax_q == AX_LAST) begin
                state_d = ST_DGO;
              end else begin
                ax_d = ax_q + 1'b1;
              end
            end
            MOP_U:  mop_d = MOP_U2;
            MOP_U2: mop_d = MOP_U3;
            MOP_U3: mop_d = MOP_U6;
            MOP_U6: mop_d = MOP_A;
            MOP_A:  mop_d = MOP_B;
            MOP_B:  mop_d = MOP_FM;
            MOP_FM: begin
              mop_d = MOP_T;
              ax_d  = '0;
            end
            MOP_T:  mop_d = MOP_DV;
            MOP_DV: begin
              if (ax_q == AX_LAST) begin
                state_d = ST_DONE;
              end else begin
                ax_d  = ax_q + 1'b1;
                mop_d = MOP_T;
              end
            end
            MOP_MV: begin
              if (ax_q == AX_LAST) begin
                state_d = ST_DONE;
              end else begin
                ax_d = ax_q + 1'b1;
              end
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_DGO: begin
        cmd_o.div_start = 1'b1;
        state_d = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (sts_i.div_done) begin
          mop_d = MOP_U;
          state_d = ST_MGO;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

  `LJ_ASSERT_RST(a_mul_done_in_wait, clk_i, rst_ni, sts_i.mul_done |-> state_q == ST_MWAIT)
  `LJ_ASSERT_RST(a_div_done_in_wait, clk_i, rst_ni, sts_i.div_done |-> state_q == ST_DWAIT)
  `LJ_ASSERT_RST(a_load_shows_result, clk_i, rst_ni, cmd_o.out_load |=> out_valid_o)
  `LJ_ASSERT_RST(a_busy_after_accept, clk_i, rst_ni, cmd_o.accept |=> !in_ready_o)

endmodule

FILE: hdl/lennard_jones_particle_update_unit.sv
`timescale 1ns / 1ps

// Channel   Handshake                  Payload
// input     in_valid_i / in_ready_o    req_type, other_mass, coord_x/y/z, speed_x/y/z
// output    out_valid_o / out_ready_i  new_pos_x/y/z, new_vel_x/y/z
// config    cfg_we_i (no wait)         cfg_idx_i, cfg_wdata_i
//
// One item at a time. Load and unused codes go from idle through the done state to the result register.
// A move item runs one multiply per axis in the digit-serial 4-bit multiplier.
// A force item runs 16 multiplies plus a divide.
// The next item is taken while a result waits; it then holds at its end until taken.
// Reset clears state to zero and config to its defaults at once.
module lennard_jones_particle_update_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   req_type_i,
  input  logic [lj_pkg::MASS_W-1:0]    other_mass_i,
  input  logic signed [31:0]           coord_x_i,
  input  logic signed [31:0]           coord_y_i,
  input  logic signed [31:0]           coord_z_i,
  input  logic signed [31:0]           speed_x_i,
  input  logic signed [31:0]           speed_y_i,
  input  logic signed [31:0]           speed_z_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [31:0]           new_pos_x_o,
  output logic signed [31:0]           new_pos_y_o,
  output logic signed [31:0]           new_pos_z_o,
  output logic signed [31:0]           new_vel_x_o,
  output logic signed [31:0]           new_vel_y_o,
  output logic signed [31:0]           new_vel_z_o,
  input  logic                         cfg_we_i,
  input  logic [lj_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lj_pkg::BOX_W-1:0]     cfg_wdata_i
);
  import lj_pkg::*;

  lj_cmd_t           cmd;
  lj_sts_t           sts;
  logic [DATA_W-1:0] coord [FIELD_AXES];
  logic [DATA_W-1:0] speed [FIELD_AXES];
  logic [DATA_W-1:0] pos   [FIELD_AXES];
  logic [DATA_W-1:0] vel   [FIELD_AXES];

  // gather axis fields
  assign coord[0] = coord_x_i;
  assign coord[1] = coord_y_i;
  assign coord[2] = coord_z_i;
  assign speed[0] = speed_x_i;
  assign speed[1] = speed_y_i;
  assign speed[2] = speed_z_i;

  lj_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  lj_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .other_mass_i (other_mass_i),
    .coord_i      (coord),
    .speed_i      (speed),
    .pos_o        (pos),
    .vel_o        (vel)
  );

  assign new_pos_x_o = pos[0];
  assign new_pos_y_o = pos[1];
  assign new_pos_z_o = pos[2];
  assign new_vel_x_o = vel[0];
  assign new_vel_y_o = vel[1];
  assign new_vel_z_o = vel[2];

endmodule

FILE: dv/lennard_jones_particle_update_unit_test.sv
`timescale 1ns / 1ps

module lennard_jones_particle_update_unit_test;
  import lj_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic [1:0]         kind;
    logic [MASS_W-1:0]  mass;
    logic signed [31:0] coord [3];
    logic signed [31:0] speed [3];
  } item_t;

  typedef struct {
    logic signed [31:0] pos [3];
    logic signed [31:0] vel [3];
  } state_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] req_type = '0;
  logic [MASS_W-1:0] other_mass = '0;
  logic signed [31:0] coord_x = '0, coord_y = '0, coord_z = '0;
  logic signed [31:0] speed_x = '0, speed_y = '0, speed_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [BOX_W-1:0] cfg_wdata = '0;

  // Shadow of the particle and its registers
  logic signed [31:0] part_pos [3];
  logic signed [31:0] part_vel [3];
  logic [BOX_W-1:0] wall [3];
  logic [15:0] dt_q;
  logic [15:0] mass_q;

  state_t expected_states [$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_cnt = 0;

  lennard_jones_particle_update_unit u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .req_type_i(req_type), .other_mass_i(other_mass),
    .coord_x_i(coord_x), .coord_y_i(coord_y), .coord_z_i(coord_z),
    .speed_x_i(speed_x), .speed_y_i(speed_y), .speed_z_i(speed_z),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .new_pos_x_o(pos_x), .new_pos_y_o(pos_y), .new_pos_z_o(pos_z),
    .new_vel_x_o(vel_x), .new_vel_y_o(vel_y), .new_vel_z_o(vel_z),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Fixed-point helpers
  function automatic logic [63:0] mul_capped(logic [63:0] a, logic [63:0] b, int sh,
                                             logic [63:0] cap);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    if (p[127:64] != 0) return cap;
    p = p >> sh;
    return (p[63:0] > cap) ? cap : p[63:0];
  endfunction

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [63:0] abs64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Lennard-Jones pair force folded into the velocity
  task automatic apply_pair_force(logic [MASS_W-1:0] m, logic signed [31:0] c [3]);
    longint d [3];
    logic [63:0] cap, r2, q, s2, k24, u, u2, u3, u6, a, b, g, fm, t, dm;
    logic neg_force, neg;
    cap = 64'hffff_ffff_ffff_ffff >> FRAC_BITS;
    r2 = 0;
    for (int i = 0; i < 3; i++) begin
      d[i] = longint'(c[i]) - longint'(part_pos[i]);
      r2 += (abs64(d[i]) * abs64(d[i])) >> FRAC_BITS;
    end
    if (r2 == 0) r2 = 1;
    q = (64'd1 << (2 * FRAC_BITS)) / r2;
    if (q > cap) q = cap;
    if (m != mass_q) begin
      s2 = 4; k24 = 360;
    end else if (mass_q == 1) begin
      s2 = 1; k24 = 72;
    end else begin
      s2 = 9; k24 = 1440;
    end
    u  = mul_capped(s2, q, 0, cap);
    u2 = mul_capped(u, u, FRAC_BITS, cap);
    u3 = mul_capped(u2, u, FRAC_BITS, cap);
    u6 = mul_capped(u3, u3, FRAC_BITS, cap);
    a  = 2 * mul_capped(u6, q, FRAC_BITS, cap);
    b  = mul_capped(u3, q, FRAC_BITS, cap);
    neg_force = a >= b;
    g  = neg_force ? a - b : b - a;
    fm = mul_capped(g, k24, 0, cap);
    for (int i = 0; i < 3; i++) begin
      t  = mul_capped(abs64(d[i]), fm, FRAC_BITS, cap);
      dm = mul_capped(t, {48'd0, dt_q}, 16, 64'hffff_ffff_ffff_ffff >> 16);
      neg = (d[i] < 0) != neg_force;
      part_vel[i] = clip32(neg ? longint'(part_vel[i]) - longint'(dm)
                               : longint'(part_vel[i]) + longint'(dm));
    end
  endtask

  // Euler step with reflection off zero and the wall
  task automatic move_particle();
    longint p, w, sm;
    for (int i = 0; i < 3; i++) begin
      sm = longint'((abs64(longint'(part_vel[i])) * dt_q) >> 16);
      p = (part_vel[i] < 0) ? longint'(part_pos[i]) - sm : longint'(part_pos[i]) + sm;
      w = longint'({33'd0, wall[i]});
      if (p < 0) begin
        p = -p;
        part_vel[i] = clip32(abs64(longint'(part_vel[i])));
      end
      if (p > w) begin
        p = 2 * w - p;
        part_vel[i] = -clip32(abs64(longint'(part_vel[i])));
      end
      if (p < 0) p = 0;
      if (p > w) p = w;
      part_pos[i] = p[31:0];
    end
  endtask

  task automatic predict_item(item_t it);
    state_t s;
    case (it.kind)
      REQ_LOAD: begin
        part_pos = it.coord;
        part_vel = it.speed;
      end
      REQ_FORCE: apply_pair_force(it.mass, it.coord);
      REQ_MOVE:  move_particle();
      default: ;
    endcase
    s.pos = part_pos;
    s.vel = part_vel;
    expected_states.push_back(s);
  endtask

  // Send one item; valid stays high across back-to-back items
  task automatic send_item(item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= it.kind;
    other_mass <= it.mass;
    coord_x <= it.coord[0]; coord_y <= it.coord[1]; coord_z <= it.coord[2];
    speed_x <= it.speed[0]; speed_y <= it.speed[1]; speed_z <= it.speed[2];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_item(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_states.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // One register write; the enable drops again before the task returns, so writes never share a time step
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BOX_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_BOX_X: wall[0] = val;
      CFG_BOX_Y: wall[1] = val;
      CFG_BOX_Z: wall[2] = val;
      CFG_DT:    dt_q = val[15:0];
      CFG_MASS:  mass_q = val[15:0];
      default: ;
    endcase
  endtask

  function automatic item_t make_item(logic [1:0] k, logic [MASS_W-1:0] m,
                                      logic signed [31:0] c0, logic signed [31:0] c1,
                                      logic signed [31:0] c2, logic signed [31:0] v0,
                                      logic signed [31:0] v1, logic signed [31:0] v2);
    item_t it;
    it.kind = k; it.mass = m;
    it.coord[0] = c0; it.coord[1] = c1; it.coord[2] = c2;
    it.speed[0] = v0; it.speed[1] = v1; it.speed[2] = v2;
    return it;
  endfunction

  function automatic logic signed [31:0] rand_signed(int max_bits);
    logic signed [31:0] v;
    v = 32'($urandom() & ((64'd1 << $urandom_range(max_bits, 1)) - 1));
    return $urandom_range(1) ? -v : v;
  endfunction

  // Extremes of fields, every request code, special cases
  task automatic test_directed();
    logic signed [31:0] mx, mn;
    mx = DATA_MAX; mn = DATA_MIN;
    send_item(make_item(REQ_LOAD, '1, mx, mn, mx, mn, mx, mn));
    send_item(make_item(REQ_UNUSED, '1, mn, mx, mn, mx, mn, mx));
    send_item(make_item(REQ_FORCE, 16'd1, mx, mn, 32'sd0, 0, 0, 0));
    send_item(make_item(REQ_MOVE, 0, 0, 0, 0, 0, 0, 0));
    // zero distance saturates the force
    send_item(make_item(REQ_LOAD, 0, 32'sh10000, 32'sh20000, 32'sh30000, 0, 0, 0));
    send_item(make_item(REQ_FORCE, 16'd1, 32'sh10000, 32'sh20000, 32'sh30000, 0, 0, 0));
    send_item(make_item(REQ_FORCE, 16'd7, 32'sh18000, 32'sh20000, 32'sh28000, 0, 0, 0));
    send_item(make_item(REQ_FORCE, 16'd1, 32'sh30000, 32'sh20000, 32'sh10000, 0, 0, 0));
    send_item(make_item(REQ_MOVE, 0, 0, 0, 0, 0, 0, 0));
    // most negative velocity, reflection off zero and far overshoot of the wall
    send_item(make_item(REQ_LOAD, 0, 32'sh1000, 32'sh500000, 32'sh620000, mn, mx,
                        32'sh7000000));
    send_item(make_item(REQ_MOVE, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(REQ_MOVE, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(REQ_UNUSED, 0, 0, 0, 0, 0, 0, 0));
    drain();
    // equal masses other than one
    write_reg(CFG_MASS, 31'h7fff_0005);
    write_reg(CFG_DT, 31'd65535);
    write_reg(3'd5, '1);
    write_reg(3'd7, '0);
    send_item(make_item(REQ_LOAD, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(REQ_FORCE, 16'd5, 32'sh8000, -32'sh8000, 32'sh4000, 0, 0, 0));
    send_item(make_item(REQ_FORCE, 16'd6, -32'sh20000, 32'sh0, 32'sh20000, 0, 0, 0));
    send_item(make_item(REQ_MOVE, 0, 0, 0, 0, 0, 0, 0));
    drain();
    // walls at their extremes, zero dt
    write_reg(CFG_BOX_X, '0);
    write_reg(CFG_BOX_Y, '1);
    write_reg(CFG_BOX_Z, 31'd65536);
    send_item(make_item(REQ_LOAD, 0, 32'sh100, mx, 32'sh20000, mx, mx, mx));
    send_item(make_item(REQ_MOVE, 0, 0, 0, 0, 0, 0, 0));
    drain();
    write_reg(CFG_DT, 31'd0);
    send_item(make_item(REQ_MOVE, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(REQ_FORCE, 16'd5, 32'sh100, 32'sh100, 32'sh100, 0, 0, 0));
    drain();
  endtask

  // Mostly physical sequences: load inside the box, nearby neighbors, moves
  task automatic test_random(int snd_pct, int rcv_pct, int count);
    item_t it;
    int r;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    for (int i = 0; i < 3; i++)
      write_reg(CFG_IDX_W'(CFG_BOX_X + i),
                BOX_W'(($urandom_range(9) == 0) ? $urandom()
                                                : $urandom_range(32'h800000, 32'h10000)));
    write_reg(CFG_DT, BOX_W'($urandom_range(3) == 0 ? $urandom() : $urandom_range(4000)));
    r = $urandom_range(3);
    write_reg(CFG_MASS, BOX_W'(r == 0 ? $urandom() : r == 1 ? 1 : $urandom_range(4, 2)));
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      it = make_item(REQ_MOVE, MASS_W'($urandom()), $urandom(), $urandom(), $urandom(),
                     $urandom(), $urandom(), $urandom());
      if (r < 15) begin
        it.kind = REQ_LOAD;
        if ($urandom_range(3) != 0)
          for (int i = 0; i < 3; i++) begin
            it.coord[i] = $urandom_range(wall[i]);
            it.speed[i] = rand_signed(24);
          end
      end else if (r < 60) begin
        it.kind = REQ_FORCE;
        if ($urandom_range(1)) it.mass = mass_q;
        else if ($urandom_range(1)) it.mass = MASS_W'($urandom_range(3));
        if ($urandom_range(9) < 7)
          for (int i = 0; i < 3; i++) it.coord[i] = part_pos[i] + rand_signed(20);
      end else if (r >= 95) begin
        it.kind = REQ_UNUSED;
      end
      send_item(it);
    end
    drain();
  endtask

  // Receiver stalls at random
  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_states.size() == 0) begin
        $error("result with no item pending");
        errors++;
      end else begin
        state_t s;
        logic signed [31:0] got [6];
        logic signed [31:0] want [6];
        string names [6];
        s = expected_states.pop_front();
        got = '{pos_x, pos_y, pos_z, vel_x, vel_y, vel_z};
        want = '{s.pos[0], s.pos[1], s.pos[2], s.vel[0], s.vel[1], s.vel[2]};
        names = '{"new_pos_x", "new_pos_y", "new_pos_z", "new_vel_x", "new_vel_y",
                  "new_vel_z"};
        for (int i = 0; i < 6; i++)
          if (got[i] !== want[i]) begin
            $error("%s: expected %0d, got %0d", names[i], want[i], got[i]);
            errors++;
          end
      end
    end
  end

  // Watchdog on handshake progress
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready))
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 3; i++) begin
      part_pos[i] = 0;
      part_vel[i] = 0;
      wall[i] = 31'd6553600;
    end
    dt_q = 16'd655;
    mass_q = 16'd1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(24, 56, 410);
    test_random(56, 24, 410);
    test_random(0, 0, 410);
    repeat (300) @(posedge clk);
    if (errors == 0 && expected_states.size() == 0) begin
      $display("All tests passed");
    end else begin
      if (expected_states.size() != 0) $error("items left without a result");
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
